// ----- rtl/ecls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecls_pkg
// Shared types and constants for the Ethernet L3/L4 frame classifier.
// ----------------------------------------------------------------------------
package ecls_pkg;

  localparam int CntWidth = 32;
  localparam int NumCnt   = 10;

  localparam logic [15:0] EthArp  = 16'h0806;
  localparam logic [15:0] EthIpv4 = 16'h0800;
  localparam logic [15:0] EthIpv6 = 16'h86dd;

  localparam logic [7:0] ProtoIcmp  = 8'h01;
  localparam logic [7:0] ProtoTcp   = 8'h06;
  localparam logic [7:0] ProtoUdp   = 8'h11;
  localparam logic [7:0] ProtoIcmp6 = 8'h3a;

  localparam logic [15:0] WatchedPortRst = 16'd80;

  localparam logic [7:0] EthHdrLen  = 8'd14;
  localparam logic [7:0] ArpLen     = 8'd28;
  localparam logic [7:0] Ipv6HdrLen = 8'd40;
  localparam logic [5:0] Ipv4MinHdr = 6'd20;
  localparam logic [7:0] IcmpLen    = 8'd8;
  localparam logic [7:0] TcpLen     = 8'd20;
  localparam logic [7:0] UdpLen     = 8'd8;

  // byte offsets inside the frame
  localparam logic [7:0] PosTypeHi  = 8'd12;
  localparam logic [7:0] PosTypeLo  = 8'd13;
  localparam logic [7:0] PosIhl     = 8'd14;
  localparam logic [7:0] PosL3Start = 8'd15;
  localparam logic [7:0] PosV6Next  = 8'd20;
  localparam logic [7:0] PosV4Proto = 8'd23;
  localparam logic [7:0] PosMax     = 8'd255;

  typedef enum logic [3:0] {
    CLS_ARP     = 4'd0,
    CLS_ICMP    = 4'd1,
    CLS_ICMP6   = 4'd2,
    CLS_TCP     = 4'd3,
    CLS_HTTP    = 4'd4,
    CLS_UDP     = 4'd5,
    CLS_OTHER   = 4'd6,
    CLS_UNKNOWN = 4'd7,
    CLS_TRUNC   = 4'd8
  } pkt_class_e;

  typedef enum logic [3:0] {
    CNT_TOTAL = 4'd0,
    CNT_ARP   = 4'd1,
    CNT_IP4   = 4'd2,
    CNT_IP6   = 4'd3,
    CNT_ICMP  = 4'd4,
    CNT_ICMP6 = 4'd5,
    CNT_TCP   = 4'd6,
    CNT_HTTP  = 4'd7,
    CNT_UDP   = 4'd8,
    CNT_OTHER = 4'd9
  } cnt_idx_e;

  typedef struct packed {
    pkt_class_e        cls;
    logic              accepted;
    logic [15:0]       ether_type;
    logic [7:0]        ip_protocol;
    logic [15:0]       src_port;
    logic [15:0]       dst_port;
    logic [NumCnt-1:0] bump;
    cnt_idx_e          cnt_sel;
    logic              cnt_sel_vld;
  } frame_res_t;

endpackage

// ----- rtl/ethernet_packet_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_packet_classifier
// Classifies Ethernet frames fed one byte per word and reports one result
// word per frame with parsed header fields and per-class counts.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------
//  in       | in        | in_valid_i / in_stall_o | frame_byte_i, last_byte_i
//  out      | out       | out_valid_o/out_stall_i | class, fields, counts
//  cfg      | in        | cfg_we_i                | cfg_wdata_i (watched port)
//
// one input word per cycle while in_stall_o is low; a word waits in the input
// register and a frame's result word moves from there to the output register.
// the header parse is a single pass of logic behind the input register.
// reset clears the frame state, the counters and sets the watched port to 80.
// a stalled result only holds back the frame's last byte; other bytes flow.
// ----------------------------------------------------------------------------
module ethernet_packet_classifier import ecls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  packet_class_o,
  output logic        accepted_o,
  output logic [15:0] ether_type_o,
  output logic [7:0]  ip_protocol_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] total_count_o,
  output logic [31:0] class_count_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        out_valid_q;
  logic [15:0] watched_port_q;
  logic        fire, emit, s1_load;

  frame_res_t          res;
  logic [CntWidth-1:0] total_cnt, class_cnt;

  // the last byte needs a free output slot
  assign fire    = s1_valid_q && (!s1_last_q || !out_valid_q || !out_stall_i);
  assign emit    = fire && s1_last_q;
  assign s1_load = !s1_valid_q || fire;

  assign in_stall_o  = s1_valid_q && !fire;
  assign out_valid_o = out_valid_q;

  ecls_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (fire),
    .byte_i         (s1_byte_q),
    .last_i         (s1_last_q),
    .watched_port_i (watched_port_q),
    .res_o          (res)
  );

  ecls_counters u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (emit),
    .bump_i      (res.bump),
    .sel_i       (res.cnt_sel),
    .sel_vld_i   (res.cnt_sel_vld),
    .total_o     (total_cnt),
    .class_cnt_o (class_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_port_q <= WatchedPortRst;
    end else if (cfg_we_i) begin
      watched_port_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      s1_byte_q <= frame_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      packet_class_o <= res.cls;
      accepted_o     <= res.accepted;
      ether_type_o   <= res.ether_type;
      ip_protocol_o  <= res.ip_protocol;
      source_port_o  <= res.src_port;
      dest_port_o    <= res.dst_port;
      total_count_o  <= 32'(total_cnt);
      class_count_o  <= 32'(class_cnt);
    end
  end

endmodule

// ----- rtl/ecls_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecls_parser
// Per-frame header state and the end-of-frame class decision.
// ----------------------------------------------------------------------------
module ecls_parser import ecls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [15:0] watched_port_i,
  output frame_res_t  res_o
);

  logic [7:0]  pos_q, pos_d;
  logic [15:0] type_q, type_d;
  logic [5:0]  hlen_q, hlen_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;

  logic [5:0] ihl_bytes;
  logic [8:0] toff_cur, toff_end, rel, len;
  logic       is4, is6, hdr_ok;

  // header update for the current word
  always_comb begin
    type_d  = type_q;
    hlen_d  = hlen_q;
    proto_d = proto_q;
    sport_d = sport_q;
    dport_d = dport_q;
    ihl_bytes = {byte_i[3:0], 2'b00};
    toff_cur = (type_q == EthIpv6) ? {1'b0, EthHdrLen + Ipv6HdrLen}
                                   : {1'b0, EthHdrLen} + {3'b000, hlen_q};
    rel = {1'b0, pos_q} - toff_cur;

    if (pos_q == PosTypeHi) begin
      type_d = {byte_i, 8'h00};
    end else if (pos_q == PosTypeLo) begin
      type_d = {type_q[15:8], byte_i};
    end else if (pos_q == PosIhl && type_q == EthIpv4) begin
      hlen_d = (ihl_bytes < Ipv4MinHdr) ? Ipv4MinHdr : ihl_bytes;
    end
    if ((type_d == EthIpv4 && pos_q == PosV4Proto) ||
        (type_d == EthIpv6 && pos_q == PosV6Next)) begin
      proto_d = byte_i;
    end
    // transport ports: source in first two bytes, destination in next two
    if (pos_q >= PosL3Start && {1'b0, pos_q} >= toff_cur && rel < 9'd4) begin
      if (rel[1]) begin
        dport_d = {dport_q[7:0], byte_i};
      end else begin
        sport_d = {sport_q[7:0], byte_i};
      end
    end
    pos_d = (pos_q == PosMax) ? pos_q : pos_q + 8'd1;
  end

  // class decision on the state including this word
  always_comb begin
    len      = {1'b0, pos_d};
    toff_end = (type_d == EthIpv6) ? {1'b0, EthHdrLen + Ipv6HdrLen}
                                   : {1'b0, EthHdrLen} + {3'b000, hlen_d};
    is4      = (pos_d >= EthHdrLen) && (type_d == EthIpv4);
    is6      = (pos_d >= EthHdrLen) && (type_d == EthIpv6);
    hdr_ok   = is4 ? (len >= toff_end) : (pos_d >= EthHdrLen + Ipv6HdrLen);

    res_o             = '0;
    res_o.cls         = CLS_TRUNC;
    res_o.cnt_sel     = CNT_TOTAL;
    res_o.cnt_sel_vld = 1'b0;

    if (pos_d >= EthHdrLen) begin
      res_o.bump[CNT_TOTAL] = 1'b1;
      if (type_d == EthArp) begin
        if (pos_d >= EthHdrLen + ArpLen) begin
          res_o.cls = CLS_ARP;
          res_o.bump[CNT_ARP] = 1'b1;
          res_o.cnt_sel = CNT_ARP;
          res_o.cnt_sel_vld = 1'b1;
        end
      end else if (is4 || is6) begin
        if (hdr_ok) begin
          if (is4) begin
            res_o.bump[CNT_IP4] = 1'b1;
          end else begin
            res_o.bump[CNT_IP6] = 1'b1;
          end
          if (is4 && proto_d == ProtoIcmp) begin
            if (len >= toff_end + {1'b0, IcmpLen}) begin
              res_o.cls = CLS_ICMP;
              res_o.bump[CNT_ICMP] = 1'b1;
              res_o.cnt_sel = CNT_ICMP;
              res_o.cnt_sel_vld = 1'b1;
            end
          end else if (is6 && proto_d == ProtoIcmp6) begin
            if (len >= toff_end + {1'b0, IcmpLen}) begin
              res_o.cls = CLS_ICMP6;
              res_o.bump[CNT_ICMP6] = 1'b1;
              res_o.cnt_sel = CNT_ICMP6;
              res_o.cnt_sel_vld = 1'b1;
            end
          end else if (proto_d == ProtoTcp) begin
            if (len >= toff_end + {1'b0, TcpLen}) begin
              res_o.src_port = sport_d;
              res_o.dst_port = dport_d;
              res_o.cnt_sel_vld = 1'b1;
              if (sport_d == watched_port_i || dport_d == watched_port_i) begin
                res_o.cls = CLS_HTTP;
                res_o.bump[CNT_HTTP] = 1'b1;
                res_o.cnt_sel = CNT_HTTP;
              end else begin
                res_o.cls = CLS_TCP;
                res_o.bump[CNT_TCP] = 1'b1;
                res_o.cnt_sel = CNT_TCP;
              end
            end
          end else if (proto_d == ProtoUdp) begin
            if (len >= toff_end + {1'b0, UdpLen}) begin
              res_o.src_port = sport_d;
              res_o.dst_port = dport_d;
              res_o.cls = CLS_UDP;
              res_o.bump[CNT_UDP] = 1'b1;
              res_o.cnt_sel = CNT_UDP;
              res_o.cnt_sel_vld = 1'b1;
            end
          end else begin
            res_o.cls = CLS_UNKNOWN;
          end
        end
      end else begin
        res_o.cls = CLS_OTHER;
        res_o.bump[CNT_OTHER] = 1'b1;
        res_o.cnt_sel = CNT_OTHER;
        res_o.cnt_sel_vld = 1'b1;
      end
      res_o.ether_type = type_d;
    end

    res_o.accepted = (res_o.cls <= CLS_UDP);
    // protocol byte only counts once it actually arrived
    if ((is4 && pos_d >= PosV4Proto + 8'd1) || (is6 && pos_d >= PosV6Next + 8'd1)) begin
      res_o.ip_protocol = proto_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      type_q  <= '0;
      hlen_q  <= '0;
      proto_q <= '0;
      sport_q <= '0;
      dport_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q   <= '0;
        type_q  <= '0;
        hlen_q  <= '0;
        proto_q <= '0;
        sport_q <= '0;
        dport_q <= '0;
      end else begin
        pos_q   <= pos_d;
        type_q  <= type_d;
        hlen_q  <= hlen_d;
        proto_q <= proto_d;
        sport_q <= sport_d;
        dport_q <= dport_d;
      end
    end
  end

endmodule

// ----- rtl/ecls_counters.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecls_counters
// Bank of wrapping per-class frame counters, cleared at reset.
// ----------------------------------------------------------------------------
module ecls_counters import ecls_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_i,
  input  logic [NumCnt-1:0]   bump_i,
  input  cnt_idx_e            sel_i,
  input  logic                sel_vld_i,
  output logic [CntWidth-1:0] total_o,
  output logic [CntWidth-1:0] class_cnt_o
);

  logic [CntWidth-1:0] cnt_q [NumCnt];
  logic [CntWidth-1:0] cnt_inc [NumCnt];

  always_comb begin
    for (int i = 0; i < NumCnt; i++) begin
      cnt_inc[i] = cnt_q[i] + CntWidth'(1);
    end
    total_o     = bump_i[CNT_TOTAL] ? cnt_inc[CNT_TOTAL] : cnt_q[CNT_TOTAL];
    class_cnt_o = sel_vld_i ? cnt_inc[sel_i] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCnt; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (upd_i) begin
      for (int i = 0; i < NumCnt; i++) begin
        if (bump_i[i]) begin
          cnt_q[i] <= cnt_inc[i];
        end
      end
    end
  end

endmodule

// ----- bench/ethernet_packet_classifier_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_packet_classifier_checker
// Watches the byte and result channels of the frame classifier, rebuilds the
// header parse and the per-class counters for every accepted byte, and
// compares each accepted result word with the oldest predicted frame report.
// ----------------------------------------------------------------------------
module ethernet_packet_classifier_checker import ecls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  packet_class_i,
  input  logic        accepted_i,
  input  logic [15:0] ether_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] total_count_i,
  input  logic [31:0] class_count_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    pkt_class_e  cls;
    logic        accepted;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] total;
    logic [31:0] class_count;
  } frame_report_t;

  logic [15:0]         watched_port;
  logic [7:0]          byte_pos;
  logic [15:0]         ether_type;
  logic [7:0]          ipv4_hdr_len;
  logic [7:0]          l3_proto;
  logic [15:0]         l4_ports [2];
  logic [CntWidth-1:0] frame_counts [NumCnt];
  frame_report_t       frame_reports_q [$];
  int                  mismatches;

  function automatic int l4_offset();
    if (ether_type == EthIpv6) return EthHdrLen + Ipv6HdrLen;
    return EthHdrLen + ipv4_hdr_len;
  endfunction

  function automatic logic [CntWidth-1:0] count_frame(cnt_idx_e idx);
    frame_counts[idx] = frame_counts[idx] + 1'b1;
    return frame_counts[idx];
  endfunction

  function automatic void clear_frame();
    byte_pos     = '0;
    ether_type   = '0;
    ipv4_hdr_len = '0;
    l3_proto     = '0;
    l4_ports[0]  = '0;
    l4_ports[1]  = '0;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    int            pos;
    int            len;
    int            t;
    int            hdr;
    int            k;
    logic          is4;
    logic          is6;
    logic          hdr_ok;
    logic          ports_ok;
    pkt_class_e    cls;
    logic [31:0]   ccount;
    frame_report_t rep;
    pos = byte_pos;
    if (pos == PosTypeHi) begin
      ether_type = {b, 8'h00};
    end else if (pos == PosTypeLo) begin
      ether_type[7:0] = b;
    end else if (pos == PosIhl && ether_type == EthIpv4) begin
      hdr = 4 * b[3:0];
      ipv4_hdr_len = (hdr < Ipv4MinHdr) ? 8'(Ipv4MinHdr) : 8'(hdr);
    end
    if ((ether_type == EthIpv4 && pos == PosV4Proto) ||
        (ether_type == EthIpv6 && pos == PosV6Next)) begin
      l3_proto = b;
    end
    if (pos >= PosL3Start) begin
      t = l4_offset();
      if (pos >= t && pos < t + 4) begin
        k = (pos - t) / 2;
        l4_ports[k] = {l4_ports[k][7:0], b};
      end
    end
    if (pos != PosMax) byte_pos = 8'(pos + 1);
    if (!fin) return;

    len      = byte_pos;
    is4      = (len >= EthHdrLen) && (ether_type == EthIpv4);
    is6      = (len >= EthHdrLen) && (ether_type == EthIpv6);
    cls      = CLS_TRUNC;
    ccount   = '0;
    ports_ok = 1'b0;
    if (len >= EthHdrLen) begin
      void'(count_frame(CNT_TOTAL));
      t = l4_offset();
      if (ether_type == EthArp) begin
        if (len >= EthHdrLen + ArpLen) begin
          cls    = CLS_ARP;
          ccount = 32'(count_frame(CNT_ARP));
        end
      end else if (is4 || is6) begin
        hdr_ok = is4 ? (len >= t) : (len >= EthHdrLen + Ipv6HdrLen);
        if (hdr_ok) begin
          if (is4) void'(count_frame(CNT_IP4));
          else void'(count_frame(CNT_IP6));
          if (is4 && l3_proto == ProtoIcmp) begin
            if (len >= t + IcmpLen) begin
              cls    = CLS_ICMP;
              ccount = 32'(count_frame(CNT_ICMP));
            end
          end else if (is6 && l3_proto == ProtoIcmp6) begin
            if (len >= t + IcmpLen) begin
              cls    = CLS_ICMP6;
              ccount = 32'(count_frame(CNT_ICMP6));
            end
          end else if (l3_proto == ProtoTcp) begin
            if (len >= t + TcpLen) begin
              ports_ok = 1'b1;
              if (l4_ports[0] == watched_port || l4_ports[1] == watched_port) begin
                cls    = CLS_HTTP;
                ccount = 32'(count_frame(CNT_HTTP));
              end else begin
                cls    = CLS_TCP;
                ccount = 32'(count_frame(CNT_TCP));
              end
            end
          end else if (l3_proto == ProtoUdp) begin
            if (len >= t + UdpLen) begin
              ports_ok = 1'b1;
              cls      = CLS_UDP;
              ccount   = 32'(count_frame(CNT_UDP));
            end
          end else begin
            cls = CLS_UNKNOWN;
          end
        end
      end else begin
        cls    = CLS_OTHER;
        ccount = 32'(count_frame(CNT_OTHER));
      end
    end

    rep.cls         = cls;
    rep.accepted    = (cls <= CLS_UDP);
    rep.ether_type  = (len >= EthHdrLen) ? ether_type : 16'h0000;
    // protocol byte only counts once it has actually arrived
    rep.ip_protocol = ((is4 && len > PosV4Proto) || (is6 && len > PosV6Next)) ? l3_proto : 8'h00;
    rep.src_port    = ports_ok ? l4_ports[0] : 16'h0000;
    rep.dst_port    = ports_ok ? l4_ports[1] : 16'h0000;
    rep.total       = 32'(frame_counts[CNT_TOTAL]);
    rep.class_count = ccount;
    frame_reports_q.push_back(rep);
    clear_frame();
  endtask

  task automatic check_report();
    frame_report_t exp_r;
    logic          bad;
    if (frame_reports_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result word with no frame pending, class %0d", $time, packet_class_i);
      return;
    end
    exp_r = frame_reports_q.pop_front();
    bad = (packet_class_i !== exp_r.cls) || (accepted_i !== exp_r.accepted) ||
          (ether_type_i !== exp_r.ether_type) || (ip_protocol_i !== exp_r.ip_protocol) ||
          (source_port_i !== exp_r.src_port) || (dest_port_i !== exp_r.dst_port) ||
          (total_count_i !== exp_r.total) || (class_count_i !== exp_r.class_count);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: frame report mismatch", $time);
        $display("  exp cls=%0d acc=%0d type=%h proto=%h sp=%h dp=%h tot=%0d cc=%0d",
                 exp_r.cls, exp_r.accepted, exp_r.ether_type, exp_r.ip_protocol,
                 exp_r.src_port, exp_r.dst_port, exp_r.total, exp_r.class_count);
        $display("  got cls=%0d acc=%0d type=%h proto=%h sp=%h dp=%h tot=%0d cc=%0d",
                 packet_class_i, accepted_i, ether_type_i, ip_protocol_i,
                 source_port_i, dest_port_i, total_count_i, class_count_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_port = WatchedPortRst;
      clear_frame();
      for (int i = 0; i < NumCnt; i++) frame_counts[i] = '0;
      frame_reports_q.delete();
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // a result can never belong to a byte taken at the same edge
      if (out_valid_i && !out_stall_i) check_report();
      if (in_valid_i && !in_stall_i) parse_byte(frame_byte_i, last_byte_i);
      if (cfg_we_i) watched_port = cfg_wdata_i;
      pending_o    <= frame_reports_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- bench/tb_ethernet_packet_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ethernet_packet_classifier
// Feeds the frame classifier directed frames (short, truncated at each layer,
// every class, odd IPv4 header lengths, an oversized frame), then random
// frames over several watched-port settings and idle/stall mixes. Checking is
// done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module tb_ethernet_packet_classifier;
  import ecls_pkg::*;

  localparam int MaxFrame   = 300;
  localparam int QuietLimit = 2000;
  localparam int PhaseBytes = 60;
  localparam int PhaseMinFr = 2;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  frame_byte_i = 8'h00;
  logic        last_byte_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [3:0]  packet_class_o;
  logic        accepted_o;
  logic [15:0] ether_type_o;
  logic [7:0]  ip_protocol_o;
  logic [15:0] source_port_o;
  logic [15:0] dest_port_o;
  logic [31:0] total_count_o;
  logic [31:0] class_count_o;
  logic        cfg_we_i     = 1'b0;
  logic [15:0] cfg_wdata_i  = 16'h0000;

  int          frames_pending;
  int          fail_count;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          bytes_sent    = 0;
  logic [15:0] cur_port      = WatchedPortRst;
  logic [7:0]  frame_buf [MaxFrame];

  ethernet_packet_classifier dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packet_class_o (packet_class_o),
    .accepted_o     (accepted_o),
    .ether_type_o   (ether_type_o),
    .ip_protocol_o  (ip_protocol_o),
    .source_port_o  (source_port_o),
    .dest_port_o    (dest_port_o),
    .total_count_o  (total_count_o),
    .class_count_o  (class_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  ethernet_packet_classifier_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .frame_byte_i   (frame_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packet_class_i (packet_class_o),
    .accepted_i     (accepted_o),
    .ether_type_i   (ether_type_o),
    .ip_protocol_i  (ip_protocol_o),
    .source_port_i  (source_port_o),
    .dest_port_i    (dest_port_o),
    .total_count_i  (total_count_o),
    .class_count_i  (class_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pending_o      (frames_pending),
    .fail_count_o   (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic fin);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [15:0] et, input logic [7:0] ihl_b,
                            input logic [7:0] pr, input logic [15:0] sp,
                            input logic [15:0] dp, input int len);
    int hdr;
    int t;
    for (int i = 0; i < MaxFrame; i++) frame_buf[i] = 8'($urandom);
    frame_buf[PosTypeHi] = et[15:8];
    frame_buf[PosTypeLo] = et[7:0];
    t = -1;
    if (et == EthIpv4) begin
      frame_buf[PosIhl]     = ihl_b;
      frame_buf[PosV4Proto] = pr;
      hdr = 4 * ihl_b[3:0];
      if (hdr < Ipv4MinHdr) hdr = Ipv4MinHdr;
      t = EthHdrLen + hdr;
    end else if (et == EthIpv6) begin
      frame_buf[PosV6Next] = pr;
      t = EthHdrLen + Ipv6HdrLen;
    end
    if (t > 0) begin
      frame_buf[t]     = sp[15:8];
      frame_buf[t + 1] = sp[7:0];
      frame_buf[t + 2] = dp[15:8];
      frame_buf[t + 3] = dp[7:0];
    end
    for (int i = 0; i < len; i++) send_word(frame_buf[i], i == len - 1);
  endtask

  // lets every pending result out, then idles the clock while the pipeline empties
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_watched_port(input logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_port    = v;
  endtask

  function automatic logic [15:0] pick_port();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return cur_port;
    if (r == 5) return 16'h0000;
    if (r == 6) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 9))
      0:       return ProtoIcmp;
      1, 2:    return ProtoIcmp6;
      3, 4, 5: return ProtoTcp;
      6, 7:    return ProtoUdp;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    int          kind;
    int          need;
    int          len;
    int          hdr;
    logic [15:0] et;
    logic [7:0]  ihl_b;
    logic [7:0]  pr;
    kind  = $urandom_range(0, 99);
    pr    = pick_proto();
    ihl_b = {4'($urandom_range(0, 15)), 4'd5};
    need  = EthHdrLen;
    len   = 0;
    if (kind < 8) begin
      et  = 16'($urandom);
      len = $urandom_range(1, EthHdrLen - 1);
    end else if (kind < 18) begin
      et   = EthArp;
      need = EthHdrLen + ArpLen;
    end else if (kind < 60) begin
      et = EthIpv4;
      if ($urandom_range(0, 9) < 3) ihl_b[3:0] = 4'($urandom_range(0, 15));
      hdr = 4 * ihl_b[3:0];
      if (hdr < Ipv4MinHdr) hdr = Ipv4MinHdr;
      need = EthHdrLen + hdr + ((pr == ProtoTcp) ? TcpLen : UdpLen);
    end else if (kind < 88) begin
      et   = EthIpv6;
      need = EthHdrLen + Ipv6HdrLen + ((pr == ProtoTcp) ? TcpLen : UdpLen);
    end else if (kind < 98) begin
      et = 16'($urandom);
    end else begin
      // oversized frame, position counter saturates
      et  = ($urandom_range(0, 1) != 0) ? EthIpv4 : EthIpv6;
      len = $urandom_range(PosMax + 1, MaxFrame);
    end
    if (len == 0) begin
      if ($urandom_range(0, 3) != 0) len = need + $urandom_range(0, 16);
      else len = $urandom_range(EthHdrLen, need);
    end
    send_frame(et, ihl_b, pr, pick_port(), pick_port(), len);
  endtask

  // no-progress watchdog on both channels and the register port
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_ethernet_packet_classifier failed");
    $finish;
  end

  initial begin
    int start_bytes;
    int n_frames;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames, watched port at its reset value
    send_frame(EthIpv4, 8'h45, ProtoTcp, 16'd80, 16'd80, 1);
    send_frame(EthArp, 8'h00, 8'h00, 16'h0000, 16'h0000, EthHdrLen - 1);
    send_frame(EthIpv4, 8'h45, ProtoUdp, 16'h0000, 16'h0000, EthHdrLen);
    send_frame(EthArp, 8'h00, 8'h00, 16'h0000, 16'h0000, EthHdrLen + ArpLen);
    send_frame(EthArp, 8'h00, 8'h00, 16'h0000, 16'h0000, EthHdrLen + ArpLen - 1);
    send_frame(EthIpv4, 8'h45, ProtoIcmp, 16'h0000, 16'h0000, 42);
    send_frame(EthIpv4, 8'h45, ProtoTcp, 16'd1234, 16'd80, 54);
    send_frame(EthIpv4, 8'h45, ProtoTcp, 16'd80, 16'hffff, 54);
    send_frame(EthIpv4, 8'h4f, ProtoTcp, 16'h0000, 16'hffff, 94);
    // header length nibble below five, version nibble garbage
    send_frame(EthIpv4, 8'hf2, ProtoTcp, 16'hffff, 16'h0000, 54);
    send_frame(EthIpv4, 8'h45, ProtoUdp, 16'd53, 16'd53, 42);
    send_frame(EthIpv4, 8'h45, 8'hff, 16'h0000, 16'h0000, 34);
    send_frame(EthIpv4, 8'h45, ProtoUdp, 16'd7, 16'd9, 41);
    send_frame(EthIpv4, 8'h45, ProtoTcp, 16'd80, 16'd80, PosV4Proto);
    send_frame(EthIpv4, 8'h45, ProtoTcp, 16'd80, 16'd1, 53);
    send_frame(EthIpv6, 8'h00, ProtoIcmp6, 16'h0000, 16'h0000, 62);
    send_frame(EthIpv6, 8'h00, ProtoTcp, 16'd443, 16'd80, 74);
    send_frame(EthIpv6, 8'h00, ProtoUdp, 16'd1, 16'd2, 62);
    send_frame(EthIpv6, 8'h00, ProtoIcmp, 16'h0000, 16'h0000, 54);
    send_frame(EthIpv4, 8'h45, ProtoIcmp6, 16'h0000, 16'h0000, 34);
    send_frame(EthIpv6, 8'h00, ProtoUdp, 16'h0000, 16'h0000, PosV6Next + 1);
    send_frame(16'hffff, 8'h00, 8'h00, 16'h0000, 16'h0000, EthHdrLen);
    send_frame(16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000, 60);
    send_frame(EthIpv4, 8'h45, ProtoUdp, 16'd7, 16'd9, MaxFrame);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_watched_port(16'h0000);
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          set_watched_port(16'hffff);
          send_idle_pct = 73;
          stall_pct     = 0;
        end
        2: begin
          set_watched_port(16'($urandom));
          send_idle_pct = 0;
          stall_pct     = 73;
        end
        default: begin
          set_watched_port(16'd80);
          send_idle_pct = 22;
          stall_pct     = 22;
        end
      endcase
      start_bytes = bytes_sent;
      n_frames    = 0;
      while (bytes_sent - start_bytes < PhaseBytes || n_frames < PhaseMinFr) begin
        random_frame();
        n_frames++;
        if ($urandom_range(0, 7) == 0) drain();
      end
      drain();
    end

    stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_ethernet_packet_classifier passed");
    end else begin
      $display("tb_ethernet_packet_classifier failed");
    end
    $finish;
  end

endmodule

// ----- ethernet_packet_classifier.f -----
rtl/ecls_pkg.sv
rtl/ecls_parser.sv
rtl/ecls_counters.sv
rtl/ethernet_packet_classifier.sv
bench/ethernet_packet_classifier_checker.sv
bench/tb_ethernet_packet_classifier.sv
